// File: rtl/core/f2f_pkg.sv
// shared constants and types for the binary64 to binary32 narrowing multiplier
package f2f_pkg;
  localparam int unsigned ExpOffset = 1919;
  localparam logic [22:0] Frac32Mask = 23'h7FFFFF;
  localparam logic [12:0] ExpMax = 13'd254;

  typedef struct packed {
    logic        sign;
    logic        bad;
    logic [12:0] expo;
  } ctl_t;

  // leading zero count over the 52-bit fraction field, top bit first
  function automatic logic [5:0] lzc52(input logic [51:0] f);
    logic [5:0] n;
    logic       found;
    n = 6'd52;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && f[i]) begin
        n = 6'(51 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

// File: rtl/core/f64_to_f32_narrowing_multiplier.sv
// top level of the binary64 x binary64 to binary32 narrowing multiplier
// Usage: present two binary64 patterns on operand_a_i/operand_b_i with
// in_valid_i; an item is taken when in_valid_i and in_ready_o are high.
// The rounded binary32 product and an unsupported flag appear on the
// output channel with out_valid_o; taken when out_ready_i is high.
// One item is accepted every cycle while the output stage is not stalled.
// Stages: unpack with normalize and exponent, four 32x32 partial
// products, product sum and sticky, round and pack.
// A stalled receiver freezes the whole pipe; in_ready_o drops only when
// the output stage is full and not being taken, so nothing is lost.
// Reset clears all valid bits; the pipe then holds no item.
// Zero, infinity, NaN or out-of-range results give unsupported_o = 1
// and product_bits_o = 0.
module f64_to_f32_narrowing_multiplier import f2f_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] product_bits_o,
  output logic        unsupported_o
);
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        adv;
  assign adv        = !v4_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: unpack
  logic [63:0] sa_d, sb_d, sa_q, sb_q;
  ctl_t        c1_d, c1_q;
  logic [62:0] ma, mb;
  logic [10:0] fa, fb;
  logic [5:0]  za, zb;
  logic        bad_a, bad_b;
  logic [12:0] ea, eb;
  always_comb begin
    ma = operand_a_i[62:0];
    mb = operand_b_i[62:0];
    fa = ma[62:52];
    fb = mb[62:52];
    za = (fa == 11'd0) ? lzc52(ma[51:0]) : 6'd0;
    zb = (fb == 11'd0) ? lzc52(mb[51:0]) : 6'd0;
    bad_a = (ma == 63'd0) || (fa == 11'h7FF);
    bad_b = (mb == 63'd0) || (fb == 11'h7FF);
    // subnormal: leading one shifted up to bit 63, where it drops out
    sa_d = (fa == 11'd0) ? {1'b1, 63'({11'd0, ma[51:0]} << (za + 6'd12))}
                         : {1'b1, ma[51:0], 11'd0};
    sb_d = (fb == 11'd0) ? {1'b1, 63'({11'd0, mb[51:0]} << (zb + 6'd12))}
                         : {1'b1, mb[51:0], 11'd0};
    ea = (fa == 11'd0) ? 13'(13'd1 - 13'(za) - 13'd1) : {2'b0, fa};
    eb = (fb == 11'd0) ? 13'(13'd1 - 13'(zb) - 13'd1) : {2'b0, fb};
    c1_d.sign = operand_a_i[63] ^ operand_b_i[63];
    c1_d.bad  = bad_a || bad_b;
    c1_d.expo = 13'(ea + eb - 13'(ExpOffset));
  end

  // stage 2: partial products
  logic [63:0] p00_q, p01_q, p10_q, p11_q;
  ctl_t        c2_q;
  // stage 3: product high word and sticky
  logic [63:0] hi_q;
  logic        lo_nz_q;
  ctl_t        c3_q;
  logic [127:0] prod;
  assign prod = {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
              + {p11_q, 64'd0};

  // stage 4: round and pack
  logic        cy;
  logic [23:0] frac;
  logic        guard, sticky, up;
  logic [12:0] ex, ex2;
  logic [23:0] fr;
  logic [31:0] res_d;
  logic        uns_d;
  always_comb begin
    cy     = hi_q[63];
    frac   = cy ? hi_q[63:40] : hi_q[62:39];
    guard  = cy ? hi_q[39] : hi_q[38];
    sticky = lo_nz_q || (cy ? (hi_q[38:0] != 39'd0) : (hi_q[37:0] != 38'd0));
    up     = guard && (frac[0] || sticky);
    ex     = 13'(c3_q.expo + 13'(cy));
    fr     = {1'b0, frac[22:0] & Frac32Mask} + 24'(up);
    ex2    = 13'(ex + 13'(fr[23]));
    uns_d  = c3_q.bad || ex[12] || (ex == 13'd0) || (ex > ExpMax) || (ex2 > ExpMax);
    res_d  = uns_d ? 32'd0 : {c3_q.sign, ex2[7:0], fr[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      c1_q    <= c1_d;
      p00_q   <= 64'(sa_q[31:0]) * 64'(sb_q[31:0]);
      p01_q   <= 64'(sa_q[31:0]) * 64'(sb_q[63:32]);
      p10_q   <= 64'(sa_q[63:32]) * 64'(sb_q[31:0]);
      p11_q   <= 64'(sa_q[63:32]) * 64'(sb_q[63:32]);
      c2_q    <= c1_q;
      hi_q    <= prod[127:64];
      lo_nz_q <= prod[63:0] != 64'd0;
      c3_q    <= c2_q;
      product_bits_o <= res_d;
      unsupported_o  <= uns_d;
    end
  end

  assign out_valid_o = v4_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(product_bits_o))
    else $error("output changed under stall");
  a_uns_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unsupported_o |-> product_bits_o == 32'd0)
    else $error("unsupported result not zero");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("ready low with empty output");
`endif
endmodule

// File: bench/tb_f64_to_f32_narrowing_multiplier.sv
// self-checking testbench for the binary64 x binary64 to binary32 narrowing multiplier

class product_board;
  logic [31:0] want_bits[$];
  logic        want_unsup[$];
  int          errors;

  // predict the rounded binary32 product of two binary64 patterns
  function void note_operands(logic [63:0] a, logic [63:0] b);
    logic [63:0]  sig_a, sig_b, hi, lo;
    logic [127:0] prod;
    logic [22:0]  frac;
    logic [23:0]  rsum;
    int           ea, eb, ex, c, gpos;
    logic         guard, sticky, up, ok_a, ok_b;
    unpack(a, sig_a, ea, ok_a);
    unpack(b, sig_b, eb, ok_b);
    if (!ok_a || !ok_b) begin
      push(32'd0, 1'b1);
      return;
    end
    prod = {64'd0, sig_a} * {64'd0, sig_b};
    hi = prod[127:64];
    lo = prod[63:0];
    c = hi[63];
    gpos = 38 + c;
    frac = 23'(hi >> (39 + c));
    guard = hi[gpos];
    sticky = ((hi & ((64'd1 << gpos) - 64'd1)) != 0) || (lo != 0);
    up = guard & (frac[0] | sticky);
    ex = ea + eb - 1919 + c;
    if (ex < 1 || ex > 254) begin
      push(32'd0, 1'b1);
      return;
    end
    rsum = {1'b0, frac} + up;
    if (rsum[23]) ex++;
    if (ex > 254) begin
      push(32'd0, 1'b1);
      return;
    end
    push({a[63] ^ b[63], 8'(ex), rsum[22:0]}, 1'b0);
  endfunction

  function void unpack(logic [63:0] v, output logic [63:0] sig, output int e,
                       output logic ok);
    logic [10:0] fld;
    int          nz, sh;
    fld = v[62:52];
    ok = (v[62:0] != 0) && (fld != 11'h7FF);
    nz = 0;
    for (int i = 62; i >= 0 && !v[i]; i--) nz++;
    nz++;
    sh = (nz > 11) ? nz : 11;
    sig = ({1'b0, v[62:0]} << sh) | 64'h8000000000000000;
    e = ((fld == 0) ? 1 : int'(fld)) - (sh - 11);
  endfunction

  function void push(logic [31:0] bits, logic unsup);
    want_bits.push_back(bits);
    want_unsup.push_back(unsup);
  endfunction

  function void check_result(logic [31:0] bits, logic unsup);
    logic [31:0] wb;
    logic        wu;
    if (want_bits.size() == 0) begin
      report_mismatch($sformatf("unexpected item bits=%h unsup=%b", bits, unsup));
      return;
    end
    wb = want_bits.pop_front();
    wu = want_unsup.pop_front();
    if (bits !== wb) report_mismatch($sformatf("product_bits %h want %h", bits, wb));
    if (unsup !== wu) report_mismatch($sformatf("unsupported %b want %b", unsup, wu));
  endfunction

  function void report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endfunction
endclass

module tb_f64_to_f32_narrowing_multiplier;
  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i, unsupported_o;
  logic [63:0] operand_a_i, operand_b_i;
  logic [31:0] product_bits_o;

  product_board board;
  int           n_sent, n_seen;
  bit           quiet_phase, hold_long;

  f64_to_f32_narrowing_multiplier i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("f64_to_f32_narrowing_multiplier regression: fail");
    $finish;
  end

  // random binary64; without wide_range, and mostly with it, the exponent is near the binary32 product window
  function automatic logic [63:0] rand_f64(bit wide_range);
    logic [63:0] v;
    int          r;
    v = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    if (!wide_range || r < 14) v[62:52] = 11'($urandom_range(880, 1160));
    else if (r == 14) v[62:52] = 11'd0;
    else if (r == 15) v[62:52] = 11'h7FF;
    else if (r == 16) v[51:0] = $urandom_range(0, 3) == 0 ? 52'd0 : v[51:0] & 52'hFFFFF;
    return v;
  endfunction

  task automatic send_item(logic [63:0] a, logic [63:0] b);
    operand_a_i <= a;
    operand_b_i <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_operands(a, b);
    n_sent++;
    @(negedge clk_i);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.want_bits.size() != 0) @(negedge clk_i);
  endtask

  // receiver: sample at the rising edge, change ready at the falling edge
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        board.check_result(product_bits_o, unsupported_o);
        n_seen++;
      end
      @(negedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_long = 0;
        out_ready_i <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else out_ready_i <= 1'b1;
    end
  end

  initial begin
    logic [63:0] dir_a[$], dir_b[$];
    logic [63:0] one, two, fmax, fmin, sub;
    board = new();
    in_valid_i = 1'b0;
    operand_a_i = '0;
    operand_b_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    one = 64'h3FF0000000000000;
    two = 64'h4000000000000000;
    fmax = 64'h47EFFFFFE0000000;  // largest finite binary32
    fmin = 64'h3810000000000000;  // smallest normal binary32
    sub = 64'h0000000000000001;
    dir_a = '{one, 64'h8000000000000000, 64'h7FF0000000000000, 64'h7FF8000000000001,
              one, 64'hBFF0000000000000, fmax, fmax, 64'h47EFFFFFF0000000, fmin,
              fmin, 64'h3FF0000010000000, 64'h3FF0000030000000, 64'h3FF0000010000001,
              sub, 64'h000FFFFFFFFFFFFF, 64'h3FFFFFFFFFFFFFFF, 64'hFFEFFFFFFFFFFFFF,
              64'h3FF8000000000000, 64'h4330000000000000, 64'h0010000000000000};
    dir_b = '{one, one, one, one, 64'hFFF0000000000000, 64'hBFF0000000000000, one, two,
              one, one, 64'h3FE0000000000000, one, one, one, 64'h7FEFFFFFFFFFFFFF,
              64'h7FE0000000000000, 64'h3FFFFFFFFFFFFFFF, 64'hFFEFFFFFFFFFFFFF,
              64'h3FF8000000000000, 64'h0000000000000000, 64'h7FE0000000000000};
    foreach (dir_a[i]) send_item(dir_a[i], dir_b[i]);
    // all-ones and all-zeros patterns on the two operands
    send_item('1, '0);
    send_item('0, '1);
    for (int k = 0; k < 1100; k++) begin
      if (k == 300) hold_long = 1;
      if (k == 600) wait_drained();
      if (k == 1000) quiet_phase = 1;
      send_item(rand_f64(1), rand_f64(1));
    end
    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("covered %0d multiplies incl. specials, subnormals, rounding ties, range edges",
             n_sent);
    $display("checked %0d results under random stalls on both channels", n_seen);
    if (board.errors == 0 && board.want_bits.size() == 0)
      $display("f64_to_f32_narrowing_multiplier regression: pass");
    else
      $display("f64_to_f32_narrowing_multiplier regression: fail");
    $finish;
  end
endmodule

// File: files.f
rtl/core/f2f_pkg.sv
rtl/core/f64_to_f32_narrowing_multiplier.sv
bench/tb_f64_to_f32_narrowing_multiplier.sv
